FILE: hdl/line_follower_state_controller_top_assert.svh
// Assertion macros for the line follower state controller checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef LINE_FOLLOWER_STATE_CONTROLLER_TOP_ASSERT_SVH
`define LINE_FOLLOWER_STATE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LFSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lfsc_pkg.sv
// Shared types and constants of the line follower state controller.
// No dependencies; imported by every module of the block.
package lfsc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DutyW    = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIGHT_THRESHOLD  = 3'd0,
    CFG_ACCEL_HIGH_LIMIT = 3'd1,
    CFG_ACCEL_LOW_LIMIT  = 3'd2,
    CFG_BASE_DUTY        = 3'd3,
    CFG_BOOST_DUTY       = 3'd4,
    CFG_PIVOT_OUTER_DUTY = 3'd5,
    CFG_PIVOT_INNER_DUTY = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MODE_INIT     = 4'd0,
    MODE_CENTER   = 4'd1,
    MODE_RIGHT    = 4'd2,
    MODE_FARRIGHT = 4'd3,
    MODE_LEFT     = 4'd4,
    MODE_FARLEFT  = 4'd5,
    MODE_LOSTR    = 4'd6,
    MODE_LOSTL    = 4'd7,
    MODE_STOP     = 4'd8,
    MODE_PICKED   = 4'd9,
    MODE_BUMP     = 4'd10
  } mode_e;

  typedef enum logic [2:0] {
    DRIVE_HOLD    = 3'd0,
    DRIVE_FORWARD = 3'd1,
    DRIVE_ROT_R   = 3'd2,
    DRIVE_ROT_L   = 3'd3,
    DRIVE_STOP    = 3'd4
  } drive_e;

  // Pattern class mask bits, in priority order (lowest bit wins)
  localparam int unsigned ClsCenter   = 0;
  localparam int unsigned ClsRight    = 1;
  localparam int unsigned ClsFarRight = 2;
  localparam int unsigned ClsLeft     = 3;
  localparam int unsigned ClsFarLeft  = 4;
  localparam int unsigned NumCls      = 5;

  localparam logic [7:0] PatStop   = 8'd153;
  localparam logic [7:0] PatLifted = 8'd255;

  localparam logic [3:0] LampsNone   = 4'd0;
  localparam logic [3:0] LampsRight  = 4'd1;
  localparam logic [3:0] LampsLeft   = 4'd2;
  localparam logic [3:0] LampsBoth   = 4'd3;
  localparam logic [3:0] LampsBrake  = 4'd12;
  localparam logic [3:0] LampsAll    = 4'd15;

  localparam logic [15:0] RstLightThreshold = 16'd20;
  localparam logic [15:0] RstAccelHigh      = 16'd18500;
  localparam logic [15:0] RstAccelLow       = 16'd15000;
  localparam logic [DutyW-1:0] RstBaseDuty  = 7'd23;
  localparam logic [DutyW-1:0] RstBoostDuty = 7'd25;
  localparam logic [DutyW-1:0] RstPivotOut  = 7'd20;
  localparam logic [DutyW-1:0] RstPivotIn   = 7'd3;

  typedef struct packed {
    logic [7:0]         line_pattern;
    logic [5:0]         bump_bits;
    logic [15:0]        light_level;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       mode_state;
    logic [2:0]       drive_mode;
    logic [DutyW-1:0] left_duty;
    logic [DutyW-1:0] right_duty;
    logic [3:0]       lamps;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        light_threshold;
    logic signed [15:0] accel_high_limit;
    logic signed [15:0] accel_low_limit;
    logic [DutyW-1:0]   base_duty;
    logic [DutyW-1:0]   boost_duty;
    logic [DutyW-1:0]   pivot_outer_duty;
    logic [DutyW-1:0]   pivot_inner_duty;
  } cfg_t;

endpackage

FILE: hdl/line_follower_state_controller_top.sv
// A sample taken into the input register moves on to the result register, from
// which its result beat is offered on the output.
// Throughput: one sample per cycle; the input register and result register
// both advance whenever the result register is empty or being taken.
// The mode register updates as a sample moves into the result register.
// Reset: mode goes to init, config registers to their defaults, valids low.
// Config writes are always taken (ready tied high); index 7 is ignored.
module line_follower_state_controller_top import lfsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  in_item_t          item_q;
  logic              item_valid_q;
  logic [3:0]        mode_q;
  out_item_t         res_q;
  logic              res_valid_q;
  logic [NumCls-1:0] classes;
  out_item_t         res_d;
  logic              advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o  = !item_valid_q || advance;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_threshold  <= RstLightThreshold;
      cfg_q.accel_high_limit <= RstAccelHigh;
      cfg_q.accel_low_limit  <= RstAccelLow;
      cfg_q.base_duty        <= RstBaseDuty;
      cfg_q.boost_duty       <= RstBoostDuty;
      cfg_q.pivot_outer_duty <= RstPivotOut;
      cfg_q.pivot_inner_duty <= RstPivotIn;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LIGHT_THRESHOLD:  cfg_q.light_threshold  <= cfg_data_i;
        CFG_ACCEL_HIGH_LIMIT: cfg_q.accel_high_limit <= cfg_data_i;
        CFG_ACCEL_LOW_LIMIT:  cfg_q.accel_low_limit  <= cfg_data_i;
        CFG_BASE_DUTY:        cfg_q.base_duty        <= cfg_data_i[DutyW-1:0];
        CFG_BOOST_DUTY:       cfg_q.boost_duty       <= cfg_data_i[DutyW-1:0];
        CFG_PIVOT_OUTER_DUTY: cfg_q.pivot_outer_duty <= cfg_data_i[DutyW-1:0];
        CFG_PIVOT_INNER_DUTY: cfg_q.pivot_inner_duty <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  lfsc_classify u_classify (
    .pattern_i (item_q.line_pattern),
    .classes_o (classes)
  );

  lfsc_decide u_decide (
    .item_i    (item_q),
    .classes_i (classes),
    .mode_i    (mode_q),
    .cfg_i     (cfg_q),
    .result_o  (res_d)
  );

  // Input register: take a beat whenever it is empty or the held one moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  // Result register and mode register advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      mode_q      <= MODE_INIT;
    end else if (advance) begin
      res_valid_q <= 1'b1;
      mode_q      <= res_d.mode_state;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: hdl/lfsc_classify.sv
// Maps an 8-bit line sensor pattern to its set of pattern classes.
// Depends on lfsc_pkg for the class bit positions.
module lfsc_classify import lfsc_pkg::*; (
  input  logic [7:0]        pattern_i,
  output logic [NumCls-1:0] classes_o
);

  always_comb begin
    classes_o = '0;
    classes_o[ClsCenter]   = pattern_i inside {8'd24, 8'd60, 8'd126};
    classes_o[ClsRight]    = pattern_i inside {8'd16, 8'd48, 8'd32, 8'd56, 8'd252,
                                               8'd248, 8'd124, 8'd120, 8'd127};
    classes_o[ClsFarRight] = pattern_i inside {8'd96, 8'd64, 8'd192, 8'd128, 8'd240,
                                               8'd112, 8'd224, 8'd120, 8'd127};
    classes_o[ClsLeft]     = pattern_i inside {8'd8, 8'd12, 8'd4, 8'd28, 8'd30, 8'd31,
                                               8'd63, 8'd61, 8'd62, 8'd254};
    classes_o[ClsFarLeft]  = pattern_i inside {8'd6, 8'd2, 8'd3, 8'd1, 8'd15, 8'd7,
                                               8'd14, 8'd254};
  end

endmodule

FILE: hdl/lfsc_decide.sv
// Next-mode decision and motor/lamp command for one sensor sample.
// Depends on lfsc_pkg; takes the class mask from lfsc_classify.
module lfsc_decide import lfsc_pkg::*; (
  input  in_item_t          item_i,
  input  logic [NumCls-1:0] classes_i,
  input  logic [3:0]        mode_i,
  input  cfg_t              cfg_i,
  output out_item_t         result_o
);

  mode_e             cur;
  mode_e             nxt;
  mode_e             fallback;
  logic [NumCls-1:0] allowed;
  logic [NumCls-1:0] hit;
  logic              bright;
  logic              picked_up;
  logic              bumped;

  // Unreachable codes behave as init
  assign cur = (mode_i > MODE_BUMP) ? MODE_INIT : mode_e'(mode_i);

  assign bright    = item_i.light_level > cfg_i.light_threshold;
  assign picked_up = ($signed(item_i.accel_z) > $signed(cfg_i.accel_high_limit)) ||
                     ($signed(item_i.accel_z) < $signed(cfg_i.accel_low_limit));
  assign bumped    = item_i.bump_bits != '0;
  assign hit       = classes_i & allowed;

  always_comb begin
    allowed  = '0;
    fallback = MODE_LOSTR;
    case (cur)
      MODE_CENTER: begin
        allowed[ClsCenter] = 1'b1; allowed[ClsRight] = 1'b1; allowed[ClsLeft] = 1'b1;
        fallback = MODE_LOSTL;
      end
      MODE_RIGHT: begin
        allowed = '1; allowed[ClsFarLeft] = 1'b0;
        fallback = MODE_LOSTL;
      end
      MODE_FARRIGHT: begin
        allowed[ClsRight] = 1'b1; allowed[ClsFarRight] = 1'b1;
        fallback = MODE_LOSTL;
      end
      MODE_LEFT: begin
        allowed = '1; allowed[ClsFarRight] = 1'b0;
      end
      MODE_FARLEFT: begin
        allowed[ClsLeft] = 1'b1; allowed[ClsFarLeft] = 1'b1;
      end
      MODE_LOSTL: begin
        allowed = '1;
        fallback = MODE_LOSTL;
      end
      MODE_STOP:   fallback = MODE_STOP;
      MODE_PICKED: fallback = MODE_PICKED;
      default:     allowed = '1;
    endcase
  end

  always_comb begin
    if (cur == MODE_STOP) begin
      nxt = (bright && item_i.line_pattern != PatStop) ? MODE_INIT : MODE_STOP;
    end else if (cur == MODE_PICKED) begin
      nxt = (bright && item_i.line_pattern != PatLifted) ? MODE_INIT : MODE_PICKED;
    end else if (cur != MODE_INIT && picked_up) begin
      nxt = MODE_PICKED;
    end else if (!bumped && bright && hit != '0) begin
      // first allowed class wins
      if (hit[ClsCenter])        nxt = MODE_CENTER;
      else if (hit[ClsRight])    nxt = MODE_RIGHT;
      else if (hit[ClsFarRight]) nxt = MODE_FARRIGHT;
      else if (hit[ClsLeft])     nxt = MODE_LEFT;
      else                       nxt = MODE_FARLEFT;
    end else if (bumped && bright) begin
      nxt = MODE_BUMP;
    end else if (!bright || item_i.line_pattern == PatStop) begin
      nxt = MODE_STOP;
    end else begin
      nxt = fallback;
    end
  end

  always_comb begin
    result_o            = '0;
    result_o.mode_state = nxt;
    result_o.drive_mode = DRIVE_HOLD;
    case (nxt)
      MODE_CENTER: begin
        result_o.drive_mode = DRIVE_FORWARD;
        result_o.left_duty  = cfg_i.base_duty;
        result_o.right_duty = cfg_i.base_duty;
        result_o.lamps      = LampsBoth;
      end
      MODE_RIGHT: begin
        result_o.drive_mode = DRIVE_FORWARD;
        result_o.left_duty  = cfg_i.base_duty;
        result_o.right_duty = cfg_i.boost_duty;
        result_o.lamps      = LampsRight;
      end
      MODE_FARRIGHT: begin
        result_o.drive_mode = DRIVE_FORWARD;
        result_o.left_duty  = cfg_i.pivot_inner_duty;
        result_o.right_duty = cfg_i.pivot_outer_duty;
        result_o.lamps      = LampsRight;
      end
      MODE_LEFT: begin
        result_o.drive_mode = DRIVE_FORWARD;
        result_o.left_duty  = cfg_i.boost_duty;
        result_o.right_duty = cfg_i.base_duty;
        result_o.lamps      = LampsLeft;
      end
      MODE_FARLEFT: begin
        result_o.drive_mode = DRIVE_FORWARD;
        result_o.left_duty  = cfg_i.pivot_outer_duty;
        result_o.right_duty = cfg_i.pivot_inner_duty;
        result_o.lamps      = LampsLeft;
      end
      MODE_LOSTR: begin
        result_o.drive_mode = DRIVE_ROT_R;
        result_o.left_duty  = cfg_i.base_duty;
        result_o.right_duty = cfg_i.base_duty;
        result_o.lamps      = LampsBrake;
      end
      MODE_LOSTL: begin
        result_o.drive_mode = DRIVE_ROT_L;
        result_o.left_duty  = cfg_i.base_duty;
        result_o.right_duty = cfg_i.base_duty;
        result_o.lamps      = LampsBrake;
      end
      MODE_BUMP: begin
        result_o.drive_mode = DRIVE_STOP;
        result_o.lamps      = LampsAll;
      end
      MODE_STOP, MODE_PICKED: begin
        result_o.drive_mode = DRIVE_STOP;
        result_o.lamps      = LampsNone;
      end
      default: result_o.lamps = LampsNone;
    endcase
  end

endmodule

FILE: hdl/lfsc_checker.sv
// Port-level checks for line_follower_state_controller_top, bound below.
// Depends on lfsc_pkg and the assertion macro header.
`include "line_follower_state_controller_top_assert.svh"

module lfsc_checker import lfsc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_item_t           out_data_o
);

  // hold a stalled result beat
  `LFSC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat dropped or changed while stalled")

  // input only stalls behind a stalled result
  `LFSC_ASSERT_NOW(a_in_stall, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without a stalled result")

  `LFSC_ASSERT_NOW(a_stop_zero, out_valid_o && out_data_o.drive_mode == DRIVE_STOP, out_data_o.left_duty == '0 && out_data_o.right_duty == '0, "stop command with nonzero duty")

  `LFSC_ASSERT_NOW(a_init_hold, out_valid_o && out_data_o.mode_state == MODE_INIT, out_data_o.drive_mode == DRIVE_HOLD && out_data_o.lamps == LampsNone, "init result not a hold")

  `LFSC_ASSERT_NOW(a_mode_range, out_valid_o, out_data_o.mode_state <= MODE_BUMP, "result mode out of range")

endmodule

bind line_follower_state_controller_top lfsc_checker u_lfsc_checker (.*);
